// File: rtl/sdspi_pkg.sv
`timescale 1ns / 1ps

package sdspi_pkg;

    // Configuration port address width: two 16-bit registers at byte addresses 0 and 4.
    localparam int unsigned CFG_ADDR_W = 3;

    // Command codes carried in the input word's tuser.
    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_DONE  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    // Completion codes of a finished block.
    localparam logic [1:0] FINISH_OK       = 2'd0;
    localparam logic [1:0] FINISH_CRC_ERR  = 2'd1;
    localparam logic [1:0] FINISH_NOT_INIT = 2'd2;

    // Sequencer state code that is visible on the result port.
    localparam logic [4:0] CARD_STATE_READY = 5'd8;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_XFER     = 2'd1,
        KIND_FINISHED = 2'd2
    } result_kind_t;

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic        data_crc_good;
        logic [7:0]  response_third;
        logic [7:0]  response_second;
        logic [7:0]  response_first;
        logic        transfer_ok;
        logic [31:0] block_number;
    } item_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]  card_kind;
        logic [4:0]  card_state;
        logic [31:0] finished_block;
        logic [1:0]  finish_code;
        logic        receive_into_data;
        logic        send_from_data;
        logic [9:0]  receive_length;
        logic [9:0]  send_length;
        logic [7:0]  frame_crc_byte;
        logic [31:0] frame_argument;
        logic [7:0]  frame_first_byte;
    } result_t;

    typedef struct packed {
        logic [15:0] init_retry_ticks;
        logic [15:0] token_retry_ticks;
    } cfg_t;

endpackage

// File: rtl/sdspi_cfg.sv
`timescale 1ns / 1ps

module sdspi_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdspi_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output sdspi_pkg::cfg_t                  cfg
);

    localparam logic [15:0] INIT_RETRY_RESET  = 16'd100;
    localparam logic [15:0] TOKEN_RETRY_RESET = 16'd10;

    logic [15:0] init_retry_reg;
    logic [15:0] token_retry_reg;
    logic        wr_en;

    // Register index is the word address bit.
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_retry_reg  <= INIT_RETRY_RESET;
            token_retry_reg <= TOKEN_RETRY_RESET;
        end else if (wr_en) begin
            if (paddr[2]) begin
                token_retry_reg <= pwdata[15:0];
            end else begin
                init_retry_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = {16'd0, (paddr[2] ? token_retry_reg : init_retry_reg)};
    assign cfg.init_retry_ticks  = init_retry_reg;
    assign cfg.token_retry_ticks = token_retry_reg;

endmodule

// File: rtl/sdspi_seq.sv
`timescale 1ns / 1ps

module sdspi_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic [2:0]              command,
    input  sdspi_pkg::item_t        item,
    input  sdspi_pkg::cfg_t         cfg,
    output sdspi_pkg::result_kind_t res_kind,
    output sdspi_pkg::result_t      res
);

    typedef enum logic [4:0] {
        ST_UNDEF   = 5'd0,
        ST_RESET   = 5'd1,
        ST_RESET2  = 5'd2,
        ST_CMD8    = 5'd3,
        ST_A41_1   = 5'd4,
        ST_A41_2   = 5'd5,
        ST_A41_3   = 5'd6,
        ST_OCR     = 5'd7,
        ST_READY   = 5'd8,
        ST_RD_CMD  = 5'd9,
        ST_RD_TOK  = 5'd10,
        ST_RD_TOK2 = 5'd11,
        ST_RD_DATA = 5'd12,
        ST_WR_CMD  = 5'd13,
        ST_WR_DATA = 5'd14,
        ST_WR_BUSY = 5'd15,
        ST_WR_STAT = 5'd16,
        ST_ERROR   = 5'd17
    } state_t;

    localparam logic [5:0] IDX_GO_IDLE      = 6'd0;
    localparam logic [5:0] IDX_SEND_IF_COND = 6'd8;
    localparam logic [5:0] IDX_SEND_STATUS  = 6'd13;
    localparam logic [5:0] IDX_READ_SINGLE  = 6'd17;
    localparam logic [5:0] IDX_WRITE_SINGLE = 6'd24;
    localparam logic [5:0] IDX_SD_OP_COND   = 6'd41;
    localparam logic [5:0] IDX_APP_CMD      = 6'd55;
    localparam logic [5:0] IDX_READ_OCR     = 6'd58;

    localparam logic [1:0] CARD_UNKNOWN = 2'd0;
    localparam logic [1:0] CARD_V1      = 2'd1;
    localparam logic [1:0] CARD_V2_SC   = 2'd2;
    localparam logic [1:0] CARD_HC      = 2'd3;

    localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG     = 32'h4000_0000;
    localparam logic [7:0]  CRC_CMD0    = 8'h95;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  CRC_NONE    = 8'hFF;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;
    localparam logic [7:0]  DATA_TOKEN  = 8'hFE;
    localparam logic [7:0]  DRESP_MASK  = 8'h1F;
    localparam logic [7:0]  DRESP_OK    = 8'h05;
    localparam logic [9:0]  LEN_FRAME   = 10'd6;
    localparam logic [9:0]  LEN_BLOCK   = 10'd515;
    localparam logic [9:0]  LEN_R1      = 10'd3;
    localparam logic [9:0]  LEN_R2      = 10'd4;
    localparam logic [9:0]  LEN_R7      = 10'd7;
    localparam logic [9:0]  LEN_POLL    = 10'd1;

    state_t      state_reg, state_next;
    state_t      sat_reg, sat_next;
    logic        pending_reg, pending_next;
    logic [15:0] wait_reg, wait_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] block_reg, block_next;
    logic [23:0] resp_reg, resp_next;
    logic        crc_reg, crc_next;
    logic        lastrx_reg, lastrx_next;

    logic        do_xfer;
    state_t      xfer_state;
    logic        xfer_rxd;
    logic [15:0] wait_dec;
    logic [31:0] blk_arg;
    logic [7:0]  r0, r1, r2;
    sdspi_pkg::result_t res_c;

    // Six-byte command frame with its expected response length.
    function automatic sdspi_pkg::result_t cmd_frame(input logic [5:0] idx,
                                                     input logic [31:0] arg);
        sdspi_pkg::result_t r;
        r = '0;
        r.frame_first_byte = {2'b01, idx};
        r.frame_argument   = arg;
        r.frame_crc_byte   = CRC_NONE;
        r.send_length      = LEN_FRAME;
        r.receive_length   = LEN_R1;
        if (idx == IDX_GO_IDLE) begin
            r.frame_crc_byte = CRC_CMD0;
        end else if (idx == IDX_SEND_IF_COND) begin
            r.frame_crc_byte = CRC_CMD8;
            r.receive_length = LEN_R7;
        end else if (idx == IDX_READ_OCR) begin
            r.receive_length = LEN_R7;
        end else if (idx == IDX_SEND_STATUS) begin
            r.receive_length = LEN_R2;
        end
        return r;
    endfunction

    function automatic sdspi_pkg::result_t poll_req();
        sdspi_pkg::result_t r;
        r = '0;
        r.receive_length = LEN_POLL;
        return r;
    endfunction

    assign r0 = resp_reg[7:0];
    assign r1 = resp_reg[15:8];
    assign r2 = resp_reg[23:16];
    assign wait_dec = (wait_reg != 16'd0) ? (wait_reg - 16'd1) : wait_reg;
    // Standard capacity cards take byte addresses.
    assign blk_arg = (kind_reg == CARD_V1 || kind_reg == CARD_V2_SC)
                   ? {item.block_number[22:0], 9'd0} : item.block_number;

    always_comb begin
        state_next   = state_reg;
        sat_next     = sat_reg;
        pending_next = pending_reg;
        wait_next    = wait_reg;
        kind_next    = kind_reg;
        block_next   = block_reg;
        resp_next    = resp_reg;
        crc_next     = crc_reg;
        lastrx_next  = lastrx_reg;
        res_kind     = sdspi_pkg::KIND_STATUS;
        res_c        = '0;
        do_xfer      = 1'b0;
        xfer_state   = ST_UNDEF;
        xfer_rxd     = 1'b0;

        unique case (command) inside
            sdspi_pkg::CMD_INIT: begin
                kind_next  = CARD_UNKNOWN;
                state_next = ST_UNDEF;
                res_c      = cmd_frame(IDX_GO_IDLE, 32'd0);
                do_xfer    = 1'b1;
                xfer_state = ST_RESET;
            end
            sdspi_pkg::CMD_READ, sdspi_pkg::CMD_WRITE: begin
                block_next = item.block_number;
                if (state_reg == ST_READY && !pending_reg) begin
                    do_xfer = 1'b1;
                    if (command == sdspi_pkg::CMD_READ) begin
                        res_c      = cmd_frame(IDX_READ_SINGLE, blk_arg);
                        xfer_state = ST_RD_CMD;
                    end else begin
                        res_c      = cmd_frame(IDX_WRITE_SINGLE, blk_arg);
                        xfer_state = ST_WR_CMD;
                    end
                end else begin
                    res_kind             = sdspi_pkg::KIND_FINISHED;
                    res_c.finish_code    = sdspi_pkg::FINISH_NOT_INIT;
                    res_c.finished_block = item.block_number;
                end
            end
            sdspi_pkg::CMD_DONE: begin
                if (pending_reg) begin
                    if (lastrx_reg) begin
                        crc_next = item.data_crc_good;
                    end else begin
                        resp_next = {item.response_third, item.response_second,
                                     item.response_first};
                    end
                    state_next   = item.transfer_ok ? sat_reg : ST_ERROR;
                    pending_next = 1'b0;
                end
            end
            sdspi_pkg::CMD_TICK: begin
                if (!pending_reg) begin
                    unique case (state_reg) inside
                        ST_RESET, ST_RESET2: begin
                            if (r1 == R1_IDLE) begin
                                res_c      = cmd_frame(IDX_SEND_IF_COND, IF_COND_ARG);
                                do_xfer    = 1'b1;
                                xfer_state = ST_CMD8;
                            end else if (state_reg == ST_RESET) begin
                                // First CMD0 is retried once.
                                res_c      = cmd_frame(IDX_GO_IDLE, 32'd0);
                                do_xfer    = 1'b1;
                                xfer_state = ST_RESET2;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        ST_CMD8: begin
                            if (r1 == R1_IDLE) begin
                                kind_next  = CARD_V2_SC;
                                res_c      = cmd_frame(IDX_APP_CMD, 32'd0);
                                do_xfer    = 1'b1;
                                xfer_state = ST_A41_1;
                            end else begin
                                kind_next  = CARD_V1;
                                state_next = ST_ERROR;
                            end
                        end
                        ST_A41_1: begin
                            if (r1 == R1_IDLE) begin
                                res_c = cmd_frame(IDX_SD_OP_COND,
                                                  (kind_reg == CARD_V1) ? 32'd0 : HCS_ARG);
                                do_xfer    = 1'b1;
                                xfer_state = ST_A41_2;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        ST_A41_2: begin
                            if (r1 == R1_IDLE) begin
                                wait_next  = cfg.init_retry_ticks;
                                state_next = ST_A41_3;
                            end else if (r1 == R1_READY) begin
                                res_c      = cmd_frame(IDX_READ_OCR, 32'd0);
                                do_xfer    = 1'b1;
                                xfer_state = ST_OCR;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        ST_A41_3: begin
                            wait_next = wait_dec;
                            if (wait_dec == 16'd0) begin
                                res_c      = cmd_frame(IDX_APP_CMD, 32'd0);
                                do_xfer    = 1'b1;
                                xfer_state = ST_A41_1;
                            end
                        end
                        ST_OCR: begin
                            if (r1 == R1_READY) begin
                                if (kind_reg == CARD_V2_SC && r2[6]) begin
                                    kind_next = CARD_HC;
                                end
                                state_next = ST_READY;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        ST_RD_CMD: begin
                            if (r1 == R1_READY || r2 == R1_READY) begin
                                res_c      = poll_req();
                                do_xfer    = 1'b1;
                                xfer_state = ST_RD_TOK;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        ST_RD_TOK: begin
                            if (r0 == DATA_TOKEN) begin
                                res_c.receive_length = LEN_BLOCK;
                                do_xfer    = 1'b1;
                                xfer_rxd   = 1'b1;
                                xfer_state = ST_RD_DATA;
                            end else begin
                                state_next = ST_RD_TOK2;
                                wait_next  = cfg.token_retry_ticks;
                            end
                        end
                        ST_RD_TOK2: begin
                            wait_next = wait_dec;
                            if (wait_dec == 16'd0) begin
                                res_c      = poll_req();
                                do_xfer    = 1'b1;
                                xfer_state = ST_RD_TOK;
                            end
                        end
                        ST_RD_DATA: begin
                            state_next           = ST_READY;
                            res_kind             = sdspi_pkg::KIND_FINISHED;
                            res_c.finish_code    = crc_reg ? sdspi_pkg::FINISH_OK
                                                           : sdspi_pkg::FINISH_CRC_ERR;
                            res_c.finished_block = block_reg;
                        end
                        ST_WR_CMD: begin
                            if (r1 == R1_READY) begin
                                res_c.send_length    = LEN_BLOCK;
                                res_c.receive_length = LEN_R1;
                                res_c.send_from_data = 1'b1;
                                do_xfer    = 1'b1;
                                xfer_state = ST_WR_DATA;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        ST_WR_DATA: begin
                            if ((r0 & DRESP_MASK) == DRESP_OK) begin
                                res_c      = poll_req();
                                do_xfer    = 1'b1;
                                xfer_state = ST_WR_BUSY;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        ST_WR_BUSY: begin
                            do_xfer = 1'b1;
                            if (r0 == 8'h00) begin
                                res_c      = poll_req();
                                xfer_state = ST_WR_BUSY;
                            end else begin
                                res_c      = cmd_frame(IDX_SEND_STATUS, 32'd0);
                                xfer_state = ST_WR_STAT;
                            end
                        end
                        ST_WR_STAT: begin
                            if (r1 == R1_READY) begin
                                state_next           = ST_READY;
                                res_kind             = sdspi_pkg::KIND_FINISHED;
                                res_c.finish_code    = sdspi_pkg::FINISH_OK;
                                res_c.finished_block = block_reg;
                            end else begin
                                state_next = ST_ERROR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (do_xfer) begin
            res_kind                = sdspi_pkg::KIND_XFER;
            res_c.receive_into_data = xfer_rxd;
            pending_next            = 1'b1;
            lastrx_next             = xfer_rxd;
            sat_next                = xfer_state;
        end
        res_c.card_state = state_next;
        res_c.card_kind  = kind_next;
        res = res_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_UNDEF;
            sat_reg     <= ST_UNDEF;
            pending_reg <= 1'b0;
            wait_reg    <= 16'd0;
            kind_reg    <= CARD_UNKNOWN;
            block_reg   <= 32'd0;
            resp_reg    <= 24'd0;
            crc_reg     <= 1'b0;
            lastrx_reg  <= 1'b0;
        end else if (step_en) begin
            state_reg   <= state_next;
            sat_reg     <= sat_next;
            pending_reg <= pending_next;
            wait_reg    <= wait_next;
            kind_reg    <= kind_next;
            block_reg   <= block_next;
            resp_reg    <= resp_next;
            crc_reg     <= crc_next;
            lastrx_reg  <= lastrx_next;
        end
    end

endmodule

// File: rtl/sd_card_spi_init_rw_sequencer.sv
`timescale 1ns / 1ps

// SPI-mode SD card sequencer. Each input word is one event: an init, read-block or
// write-block request, a transfer-done report from the external transfer engine, or a
// main-loop tick. Every input word produces exactly one result word, which is either
// a plain status, a transfer request for the engine (frame bytes, lengths, buffer
// choice) or a block completion, and always carries the sequencer state and the card
// kind. An accepted word sits in the input register while the next-state logic works on
// it and then moves into the result register, from which its result can be taken. The
// block accepts a new word in every cycle unless the output stalls; the result register
// parts the two sides, so a waiting result stops the input only once the input register
// holds a word as well. The user must write the retry tick counts through the
// configuration port only while no word is in flight; the block itself does not
// enforce this.
module sd_card_spi_init_rw_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] block_number, [32] transfer_ok, [40:33] response_first,
    // [48:41] response_second, [56:49] response_third, [57] data_crc_good
    input  logic [63:0]                      s_tdata,
    // [2:0] command
    input  logic [2:0]                       s_tuser,
    // Result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] frame_first_byte, [39:8] frame_argument, [47:40] frame_crc_byte,
    // [57:48] send_length, [67:58] receive_length, [68] send_from_data,
    // [69] receive_into_data, [71:70] finish_code, [103:72] finished_block,
    // [108:104] card_state, [110:109] card_kind
    output logic [111:0]                     m_tdata,
    // [1:0] result_kind
    output logic [1:0]                       m_tuser,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdspi_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic                    in_valid_reg;
    logic [2:0]              in_cmd_reg;
    sdspi_pkg::item_t        in_item_reg;
    logic                    m_valid_reg;
    sdspi_pkg::result_kind_t m_kind_reg;
    sdspi_pkg::result_t      m_res_reg;

    logic                    out_adv;
    logic                    step_en;
    sdspi_pkg::cfg_t         cfg;
    sdspi_pkg::result_kind_t step_kind;
    sdspi_pkg::result_t      step_res;

    assign pready = 1'b1;

    sdspi_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The result register can load whenever it is empty or being emptied; the input
    // register then hands its word on, and so can itself take a new word.
    assign out_adv  = !m_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_cmd_reg                  <= s_tuser;
            in_item_reg.block_number    <= s_tdata[31:0];
            in_item_reg.transfer_ok     <= s_tdata[32];
            in_item_reg.response_first  <= s_tdata[40:33];
            in_item_reg.response_second <= s_tdata[48:41];
            in_item_reg.response_third  <= s_tdata[56:49];
            in_item_reg.data_crc_good   <= s_tdata[57];
        end
    end

    sdspi_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .command  (in_cmd_reg),
        .item     (in_item_reg),
        .cfg      (cfg),
        .res_kind (step_kind),
        .res      (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= in_valid_reg;
        end
        if (step_en) begin
            m_kind_reg <= step_kind;
            m_res_reg  <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {1'b0, m_res_reg};

    // Reset empties the result register.
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // A word in the input register moves to the result register once it may load.
    a_word_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_adv |=> m_tvalid)
        else $error("word lost between input and result register");

    // A successful or CRC-failed completion always leaves the card initialised.
    a_finish_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sdspi_pkg::KIND_FINISHED
            && m_tdata[71:70] != sdspi_pkg::FINISH_NOT_INIT
        |-> m_tdata[108:104] == sdspi_pkg::CARD_STATE_READY)
        else $error("block completed outside the initialised state");

    // Every transfer request receives at least one byte.
    a_xfer_receives: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sdspi_pkg::KIND_XFER |-> m_tdata[67:58] != 10'd0)
        else $error("transfer request with no receive length");

endmodule
